[rtl/tcr_pkg.sv]
// Shared constants, codes and control structs for the threshold clip and reclassify block.
package tcr_pkg;

  localparam int SAMPLE_BITS  = 32;
  localparam int NUM_CLASSES  = 8;
  localparam int CLASS_IDX_W  = 3;
  localparam int CLASS_CNT_W  = 4;
  localparam int RULE_EN_W    = 3;
  localparam int RULE_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // Input item kinds.
  localparam logic MODE_CLASSIFY = 1'b0;
  localparam logic MODE_WRITE    = 1'b1;

  // Bits of the rule enable register.
  localparam int EN_BELOW = 0;
  localparam int EN_CLASS = 1;
  localparam int EN_ABOVE = 2;

  typedef enum logic [RULE_W-1:0] {
    RULE_PASS  = 2'd0,
    RULE_ABOVE = 2'd1,
    RULE_BELOW = 2'd2,
    RULE_CLASS = 2'd3
  } rule_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE_ENABLES    = 3'd0,
    CFG_HIGH_LIMIT      = 3'd1,
    CFG_ABOVE_VALUE     = 3'd2,
    CFG_ABOVE_IS_NODATA = 3'd3,
    CFG_LOW_LIMIT       = 3'd4,
    CFG_BELOW_VALUE     = 3'd5,
    CFG_BELOW_IS_NODATA = 3'd6,
    CFG_CLASS_COUNT     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic tbl_wr;   // store the class entry of the accepted request
    logic capture;  // register the sample of the accepted request
    logic cmp;      // register the limit and range compares
    logic sel;      // choose the replacement and load the result register
  } tcr_cmd_t;

  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } tcr_sts_t;

endpackage

[rtl/tcr_ctrl.sv]
// Controller state machine that sequences one request through compare and select.
module tcr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_stall,
  input  tcr_pkg::tcr_sts_t sts,
  output tcr_pkg::tcr_cmd_t cmd
);
  import tcr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_SEL  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.tbl_wr  = accept && (in_mode == MODE_WRITE);
    cmd.capture = accept && (in_mode == MODE_CLASSIFY);
    cmd.cmp     = (state_r == S_CMP);
    cmd.sel     = (state_r == S_SEL) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_capture_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_CMP)
    else $error("captured sample did not move to compare");

  a_cmp_to_sel: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |=> state_r == S_SEL)
    else $error("compare did not move to select");

  a_sel_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL) && sts.out_free |=> state_r == S_IDLE)
    else $error("select did not return to idle once the result was loaded");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tbl_wr |=> state_r == S_IDLE)
    else $error("table write started a classification");
`endif

endmodule

[rtl/tcr_dp.sv]
// Datapath: configuration registers, class table, compares and result register.
module tcr_dp (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [tcr_pkg::CFG_DATA_W-1:0]            cfg_wdata,
  input  logic signed [tcr_pkg::SAMPLE_BITS-1:0]    in_sample,
  input  logic                                      in_sample_nodata,
  input  logic [tcr_pkg::CLASS_IDX_W-1:0]           in_entry_index,
  input  logic signed [tcr_pkg::SAMPLE_BITS-1:0]    in_entry_low,
  input  logic signed [tcr_pkg::SAMPLE_BITS-1:0]    in_entry_high,
  input  logic signed [tcr_pkg::SAMPLE_BITS-1:0]    in_entry_value,
  input  logic                                      in_entry_value_nodata,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [tcr_pkg::SAMPLE_BITS-1:0]    out_result_value,
  output logic                                      out_result_nodata,
  output logic [tcr_pkg::RULE_W-1:0]                out_rule_applied,
  output logic [tcr_pkg::CLASS_IDX_W-1:0]           out_class_hit,
  input  tcr_pkg::tcr_cmd_t                         cmd,
  output tcr_pkg::tcr_sts_t                         sts
);
  import tcr_pkg::*;

  // Configuration registers.
  logic [RULE_EN_W-1:0]          rule_en_r;
  logic signed [SAMPLE_BITS-1:0] high_limit_r;
  logic signed [SAMPLE_BITS-1:0] above_value_r;
  logic                          above_nd_r;
  logic signed [SAMPLE_BITS-1:0] low_limit_r;
  logic signed [SAMPLE_BITS-1:0] below_value_r;
  logic                          below_nd_r;
  logic [CLASS_CNT_W-1:0]        class_count_r;

  // Class table; each entry is compared at its own place.
  logic signed [SAMPLE_BITS-1:0] low_tbl_r   [NUM_CLASSES];
  logic signed [SAMPLE_BITS-1:0] high_tbl_r  [NUM_CLASSES];
  logic signed [SAMPLE_BITS-1:0] value_tbl_r [NUM_CLASSES];
  logic                          nd_tbl_r    [NUM_CLASSES];

  // Captured sample and registered compare results.
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic                          samp_nd_r;
  logic                          above_r;
  logic                          below_r;
  logic [NUM_CLASSES-1:0]        match_r;
  logic [NUM_CLASSES-1:0]        match_nxt;

  // Result register.
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] res_value_r;
  logic                          res_nd_r;
  logic [RULE_W-1:0]             res_rule_r;
  logic [CLASS_IDX_W-1:0]        res_hit_r;

  logic                          hit_any;
  logic [CLASS_IDX_W-1:0]        hit_idx;
  logic signed [SAMPLE_BITS-1:0] sel_value;
  logic                          sel_nd;
  rule_t                         sel_rule;
  logic [CLASS_IDX_W-1:0]        sel_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_en_r     <= '0;
      high_limit_r  <= '0;
      above_value_r <= '0;
      above_nd_r    <= 1'b0;
      low_limit_r   <= '0;
      below_value_r <= '0;
      below_nd_r    <= 1'b0;
      class_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RULE_ENABLES:    rule_en_r     <= cfg_wdata[RULE_EN_W-1:0];
        CFG_HIGH_LIMIT:      high_limit_r  <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
        CFG_ABOVE_VALUE:     above_value_r <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
        CFG_ABOVE_IS_NODATA: above_nd_r    <= cfg_wdata[0];
        CFG_LOW_LIMIT:       low_limit_r   <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
        CFG_BELOW_VALUE:     below_value_r <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
        CFG_BELOW_IS_NODATA: below_nd_r    <= cfg_wdata[0];
        CFG_CLASS_COUNT:     class_count_r <= cfg_wdata[CLASS_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      low_tbl_r[in_entry_index]   <= in_entry_low;
      high_tbl_r[in_entry_index]  <= in_entry_high;
      value_tbl_r[in_entry_index] <= in_entry_value;
      nd_tbl_r[in_entry_index]    <= in_entry_value_nodata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp_r    <= in_sample;
      samp_nd_r <= in_sample_nodata;
    end
  end

  // An entry takes part only below the class count; a count beyond the table
  // simply enables every entry.
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      match_nxt[k] = !samp_nd_r && rule_en_r[EN_CLASS]
                     && (CLASS_CNT_W'(k) < class_count_r)
                     && (samp_r >= low_tbl_r[k]) && (samp_r <= high_tbl_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      above_r <= !samp_nd_r && rule_en_r[EN_ABOVE] && (samp_r > high_limit_r);
      below_r <= !samp_nd_r && rule_en_r[EN_BELOW] && (samp_r < low_limit_r);
      match_r <= match_nxt;
    end
  end

  // The lowest matching index wins.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (match_r[k]) begin
        hit_any = 1'b1;
        hit_idx = CLASS_IDX_W'(k);
      end
    end
  end

  always_comb begin
    sel_value = samp_r;
    sel_nd    = samp_nd_r;
    sel_rule  = RULE_PASS;
    sel_hit   = '0;
    if (above_r) begin
      sel_value = above_value_r;
      sel_nd    = above_nd_r;
      sel_rule  = RULE_ABOVE;
    end else if (below_r) begin
      sel_value = below_value_r;
      sel_nd    = below_nd_r;
      sel_rule  = RULE_BELOW;
    end else if (hit_any) begin
      sel_value = value_tbl_r[hit_idx];
      sel_nd    = nd_tbl_r[hit_idx];
      sel_rule  = RULE_CLASS;
      sel_hit   = hit_idx;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sel) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      res_value_r <= sel_value;
      res_nd_r    <= sel_nd;
      res_rule_r  <= sel_rule;
      res_hit_r   <= sel_hit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_value_r;
  assign out_result_nodata = res_nd_r;
  assign out_rule_applied = res_rule_r;
  assign out_class_hit    = res_hit_r;

`ifndef SYNTH
  a_hit_only_on_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_rule_r != RULE_CLASS) |-> res_hit_r == '0)
    else $error("class index reported without a class match");

  a_sel_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sel |-> !out_valid_r || !out_stall)
    else $error("result loaded over one still waiting");
`endif

endmodule

[rtl/threshold_clip_reclassify.sv]
// Top level of the threshold clip and reclassify block.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    mode, sample, class table entry
//   out_     output     out_valid/out_stall  result value, no-data, rule, class index
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// A classify request is accepted when the block is idle and then passes three steps:
// capture, compare of limits and all class ranges, and select, which loads the output
// register once it is free; the next request is accepted when the block is idle again.
// A table write request is stored when accepted and gives no result.
// Reset is synchronous and zeroes only config and out_valid; the table is not cleared.
// A waiting result does not block acceptance; only a second result waits in select.
module threshold_clip_reclassify (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tcr_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_mode,
  input  logic signed [tcr_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   in_sample_nodata,
  input  logic [tcr_pkg::CLASS_IDX_W-1:0]        in_entry_index,
  input  logic signed [tcr_pkg::SAMPLE_BITS-1:0] in_entry_low,
  input  logic signed [tcr_pkg::SAMPLE_BITS-1:0] in_entry_high,
  input  logic signed [tcr_pkg::SAMPLE_BITS-1:0] in_entry_value,
  input  logic                                   in_entry_value_nodata,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tcr_pkg::SAMPLE_BITS-1:0] out_result_value,
  output logic                                   out_result_nodata,
  output logic [tcr_pkg::RULE_W-1:0]             out_rule_applied,
  output logic [tcr_pkg::CLASS_IDX_W-1:0]        out_class_hit
);
  import tcr_pkg::*;

  tcr_cmd_t cmd;
  tcr_sts_t sts;

  tcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcr_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_sample             (in_sample),
    .in_sample_nodata      (in_sample_nodata),
    .in_entry_index        (in_entry_index),
    .in_entry_low          (in_entry_low),
    .in_entry_high         (in_entry_high),
    .in_entry_value        (in_entry_value),
    .in_entry_value_nodata (in_entry_value_nodata),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_value      (out_result_value),
    .out_result_nodata     (out_result_nodata),
    .out_rule_applied      (out_rule_applied),
    .out_class_hit         (out_class_hit),
    .cmd                   (cmd),
    .sts                   (sts)
  );

endmodule
